@@ rtl/pdc_pkg.sv @@
// Package for the Porter-Duff pixel compositor: rule and operation codes,
// the queued word format and the rounded divide-by-255 helper of the back end.
// Depends on nothing; every module of the compositor imports it.
package pdc_pkg;

  // Blend rule codes held in the configuration register.
  localparam logic [3:0] RULE_CLEAR    = 4'd0;
  localparam logic [3:0] RULE_SRC      = 4'd1;
  localparam logic [3:0] RULE_DST      = 4'd2;
  localparam logic [3:0] RULE_SRC_OVER = 4'd3;
  localparam logic [3:0] RULE_DST_OVER = 4'd4;
  localparam logic [3:0] RULE_SRC_IN   = 4'd5;
  localparam logic [3:0] RULE_DST_IN   = 4'd6;
  localparam logic [3:0] RULE_SRC_OUT  = 4'd7;
  localparam logic [3:0] RULE_DST_OUT  = 4'd8;
  localparam logic [3:0] RULE_SRC_ATOP = 4'd9;
  localparam logic [3:0] RULE_DST_ATOP = 4'd10;
  localparam logic [3:0] RULE_XOR      = 4'd11;
  localparam logic [3:0] RULE_RESET    = RULE_SRC_OVER;

  // Register index of the blend rule.
  localparam logic REG_BLEND_RULE = 1'b0;

  // Operation codes that the front end hands to the arithmetic back end.
  localparam logic [2:0] OP_PASS = 3'd0;  // result already known
  localparam logic [2:0] OP_OPQ  = 3'd1;  // p over an opaque q
  localparam logic [2:0] OP_OVG  = 3'd2;  // p over q, general
  localparam logic [2:0] OP_IN   = 3'd3;  // p in q, general
  localparam logic [2:0] OP_OUT  = 3'd4;  // p out q, general
  localparam logic [2:0] OP_ATOP = 3'd5;  // p atop q, general
  localparam logic [2:0] OP_XOR  = 3'd6;  // xor, general

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int DIV_STEPS   = 8;

  // One classified word: operation, the two operands in rule order and
  // the finished pixel for the shortcut cases.
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] p;
    logic [31:0] q;
    logic [31:0] pix;
  } pdc_item_t;

  // Rounded divide by 255: t = x + 0x80, ((t >> 8) + t) >> 8.
  function automatic logic [16:0] div255(input logic [23:0] x);
    logic [24:0] t;
    logic [24:0] u;
    t = {1'b0, x} + 25'd128;
    u = t + (t >> 8);
    return u[24:8];
  endfunction

endpackage

@@ rtl/pdc_front.sv @@
// Front end of the compositor: classifies a source/destination pair under
// the blend rule into a shortcut result or a general operation.
// Depends on pdc_pkg.
module pdc_front
  import pdc_pkg::*;
(
  input  logic [3:0]  rule,
  input  logic [31:0] src_pixel,
  input  logic [31:0] dst_pixel,
  output pdc_item_t   item
);

  logic [7:0] sa;
  logic [7:0] da;
  logic       s0, s1, d0, d1;

  assign sa = src_pixel[31:24];
  assign da = dst_pixel[31:24];
  assign s0 = (sa == 8'd0);
  assign s1 = (sa == 8'hFF);
  assign d0 = (da == 8'd0);
  assign d1 = (da == 8'hFF);

  // Decision tree per rule; the alpha-replacing shortcuts are built here.
  always_comb begin
    item.op  = OP_PASS;
    item.p   = src_pixel;
    item.q   = dst_pixel;
    item.pix = dst_pixel;
    case (rule)
      RULE_CLEAR: item.pix = '0;
      RULE_SRC:   item.pix = src_pixel;
      RULE_DST:   item.pix = dst_pixel;
      RULE_SRC_OVER: begin
        if (s0) item.pix = dst_pixel;
        else if (s1 || d0) item.pix = src_pixel;
        else if (d1) item.op = OP_OPQ;
        else item.op = OP_OVG;
      end
      RULE_DST_OVER: begin
        item.p = dst_pixel;
        item.q = src_pixel;
        if (s0 || d1) item.pix = dst_pixel;
        else if (d0) item.pix = src_pixel;
        else if (s1) item.op = OP_OPQ;
        else item.op = OP_OVG;
      end
      RULE_SRC_IN: begin
        if (s0 || d0) item.pix = '0;
        else if (d1) item.pix = src_pixel;
        else if (s1) item.pix = {da, src_pixel[23:0]};
        else item.op = OP_IN;
      end
      RULE_DST_IN: begin
        item.p = dst_pixel;
        item.q = src_pixel;
        if (s1) item.pix = dst_pixel;
        else if (s0 || d0) item.pix = '0;
        else if (d1) item.pix = {sa, dst_pixel[23:0]};
        else item.op = OP_IN;
      end
      RULE_SRC_OUT: begin
        if (s0 || d1) item.pix = '0;
        else if (d0) item.pix = src_pixel;
        else if (s1) item.pix = {~da, src_pixel[23:0]};
        else item.op = OP_OUT;
      end
      RULE_DST_OUT: begin
        item.p = dst_pixel;
        item.q = src_pixel;
        if (s0) item.pix = dst_pixel;
        else if (s1 || d0) item.pix = '0;
        else if (d1) item.pix = {~sa, dst_pixel[23:0]};
        else item.op = OP_OUT;
      end
      RULE_SRC_ATOP: begin
        if (s0) item.pix = dst_pixel;
        else if (d0) item.pix = '0;
        else if (s1) item.pix = {da, src_pixel[23:0]};
        else if (d1) item.op = OP_OPQ;
        else item.op = OP_ATOP;
      end
      RULE_DST_ATOP: begin
        item.p = dst_pixel;
        item.q = src_pixel;
        if (s0) item.pix = '0;
        else if (d0) item.pix = src_pixel;
        else if (s1) item.op = OP_OPQ;
        else if (d1) item.pix = {sa, dst_pixel[23:0]};
        else item.op = OP_ATOP;
      end
      RULE_XOR: begin
        if (s0) item.pix = dst_pixel;
        else if (d0) item.pix = src_pixel;
        else if (s1) item.pix = {~da, src_pixel[23:0]};
        else if (d1) item.pix = {~sa, dst_pixel[23:0]};
        else item.op = OP_XOR;
      end
      default: item.pix = dst_pixel;
    endcase
  end

endmodule

@@ rtl/pdc_queue.sv @@
// Short word queue between the classifying front end and the arithmetic
// back end, so that each side stalls on its own. Depends on pdc_pkg.
module pdc_queue
  import pdc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  pdc_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output pdc_item_t head_item
);

  pdc_item_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     count_r, count_nxt;

  assign full       = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop)) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !head_valid)) else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QPTR_W + 1)'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

@@ rtl/pdc_back.sv @@
// Arithmetic back end: two multiply stages, a combine stage, an
// eight-step pipelined divider per colour byte and the output register.
// Depends on pdc_pkg.
module pdc_back
  import pdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  pdc_item_t   head_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_new_pixel
);

  logic en;

  // Stage A: word taken from the queue.
  logic        a_valid_r;
  pdc_item_t   a_item_r;

  // Stage B: first products.
  logic        b_valid_r;
  logic [2:0]  b_op_r;
  logic [31:0] b_p_r, b_q_r, b_pix_r;
  logic [16:0] b_x_r [3];
  logic [16:0] b_y_r [3];
  logic [15:0] b_fa_r, b_g2a_r, b_g2b_r;

  // Stage C: second products and result alpha.
  logic        c_valid_r;
  logic [2:0]  c_op_r;
  logic [31:0] c_p_r, c_pix_r;
  logic [24:0] c_pp_r [3];
  logic [24:0] c_qq_r [3];
  logic [7:0]  c_na_r;

  // Divider stages; index 0 is the entry and DIV_STEPS the last step.
  logic        dv_valid_r [DIV_STEPS+1];
  logic [16:0] dv_rem_r   [DIV_STEPS+1][3];
  logic [7:0]  dv_quo_r   [DIV_STEPS+1][3];
  logic        dv_sat_r   [DIV_STEPS+1][3];
  logic [7:0]  dv_na_r    [DIV_STEPS+1];
  logic        dv_nodiv_r [DIV_STEPS+1];
  logic [31:0] dv_pix_r   [DIV_STEPS+1];

  logic        o_valid_r;
  logic [31:0] o_pixel_r;

  // The whole pipeline moves unless a result is held by the consumer.
  assign en            = !o_valid_r || !out_stall;
  assign pop           = en && head_valid;
  assign out_valid     = o_valid_r;
  assign out_new_pixel = o_pixel_r;

  // Stage A to B: widened alphas and first multiplies per operation.
  logic [16:0] ab_x [3];
  logic [16:0] ab_y [3];
  logic [15:0] ab_fa, ab_g2a, ab_g2b;

  always_comb begin
    logic [7:0]  pa, qa, cp, cq;
    logic [8:0]  wa, wca, wb;
    logic [15:0] fp, fq;
    pa  = a_item_r.p[31:24];
    qa  = a_item_r.q[31:24];
    wa  = {1'b0, pa} + 9'(pa[7]);
    wca = 9'd256 - wa;
    wb  = {1'b0, qa} + 9'(qa[7]);
    fp  = {8'd0, pa} * {8'd0, ~qa};
    fq  = {8'd0, qa} * {8'd0, ~pa};
    ab_fa  = '0;
    ab_g2a = 16'd1;
    ab_g2b = 16'd1;
    case (a_item_r.op)
      OP_OVG:  begin ab_fa = {8'd0, pa} * {8'd0, qa}; ab_g2b = {7'd0, wca}; end
      OP_IN:   ab_fa = {8'd0, pa} * {8'd0, qa};
      OP_OUT:  begin ab_fa = fp; ab_g2a = {8'd0, ~qa}; ab_g2b = '0; end
      OP_ATOP: begin ab_g2a = {7'd0, wb}; ab_g2b = {7'd0, wca}; end
      OP_XOR:  begin ab_g2a = fp; ab_g2b = fq; end
      default: ab_fa = '0;
    endcase
    for (int i = 0; i < 3; i++) begin
      cp = a_item_r.p[8*i +: 8];
      cq = a_item_r.q[8*i +: 8];
      case (a_item_r.op)
        OP_OPQ: begin
          ab_x[i] = {9'd0, cp} * {8'd0, wa};
          ab_y[i] = {9'd0, cq} * {8'd0, wca};
        end
        OP_OVG, OP_ATOP: begin
          ab_x[i] = {9'd0, cp} * {8'd0, wa};
          ab_y[i] = {9'd0, cq} * {8'd0, wb};
        end
        OP_OUT: begin
          ab_x[i] = {9'd0, cp} * {9'd0, pa};
          ab_y[i] = '0;
        end
        OP_XOR: begin
          ab_x[i] = {9'd0, cp};
          ab_y[i] = {9'd0, cq};
        end
        default: begin
          ab_x[i] = '0;
          ab_y[i] = '0;
        end
      endcase
    end
  end

  // Stage B to C: second multiplies and the result alpha.
  logic [24:0] bc_pp [3];
  logic [24:0] bc_qq [3];
  logic [7:0]  bc_na;

  always_comb begin
    logic [32:0] pm, qm;
    logic [9:0]  ovg_na;
    logic [16:0] fa_d, xor_d;
    fa_d   = div255({8'd0, b_fa_r});
    xor_d  = div255({7'd0, {1'b0, b_g2a_r} + {1'b0, b_g2b_r}});
    ovg_na = {2'd0, b_p_r[31:24]} + {2'd0, b_q_r[31:24]} - fa_d[9:0];
    case (b_op_r)
      OP_OVG:         bc_na = ovg_na[7:0];
      OP_IN, OP_OUT:  bc_na = fa_d[7:0];
      OP_ATOP:        bc_na = b_q_r[31:24];
      OP_XOR:         bc_na = xor_d[7:0];
      default:        bc_na = 8'hFF;
    endcase
    for (int i = 0; i < 3; i++) begin
      pm = {16'd0, b_x_r[i]} * {17'd0, b_g2a_r};
      qm = {16'd0, b_y_r[i]} * {17'd0, b_g2b_r};
      bc_pp[i] = pm[24:0];
      bc_qq[i] = qm[24:0];
    end
  end

  // Stage C to divider entry: numerators, shortcut finishing, saturation.
  logic [16:0] cd_num [3];
  logic        cd_sat [3];
  logic        cd_nodiv;
  logic [31:0] cd_pix;

  always_comb begin
    logic [25:0] sum;
    logic [17:0] ovg_sum;
    logic [8:0]  v;
    logic [16:0] dq;
    logic [16:0] lim;
    cd_nodiv = 1'b1;
    cd_pix   = c_pix_r;
    lim      = {1'b0, c_na_r, 8'd0};
    case (c_op_r)
      OP_OPQ:  cd_pix[31:24] = 8'hFF;
      OP_IN:   cd_pix = (c_na_r == 8'd0) ? 32'd0 : {c_na_r, c_p_r[23:0]};
      OP_OVG, OP_OUT, OP_ATOP, OP_XOR: begin
        cd_nodiv = (c_na_r == 8'd0);
        cd_pix   = '0;
      end
      default: cd_pix = c_pix_r;
    endcase
    for (int i = 0; i < 3; i++) begin
      sum     = {1'b0, c_pp_r[i]} + {1'b0, c_qq_r[i]};
      ovg_sum = {1'b0, c_pp_r[i][16:0]} + {1'b0, c_qq_r[i][24:8]};
      v       = '0;
      dq      = '0;
      case (c_op_r)
        OP_OVG:  v = ovg_sum[16:8];
        OP_ATOP: v = {1'b0, sum[23:16]};
        OP_OUT:  dq = div255(c_pp_r[i][23:0]);
        OP_XOR:  dq = div255(sum[23:0]);
        OP_OPQ:  cd_pix[8*i +: 8] = (sum[25:16] != '0) ? 8'hFF : sum[15:8];
        default: dq = '0;
      endcase
      if (c_op_r == OP_OVG || c_op_r == OP_ATOP) begin
        cd_num[i] = {v, 8'd0} - {8'd0, v};
      end else begin
        cd_num[i] = dq;
      end
      cd_sat[i] = (cd_num[i] >= lim);
    end
  end

  // One restoring step per stage: quotient bit DIV_STEPS-1-k at step k.
  logic [16:0] st_rem [DIV_STEPS][3];
  logic [7:0]  st_quo [DIV_STEPS][3];

  always_comb begin
    logic [16:0] dvs;
    for (int k = 0; k < DIV_STEPS; k++) begin
      dvs = {9'd0, dv_na_r[k]} << (DIV_STEPS - 1 - k);
      for (int i = 0; i < 3; i++) begin
        st_rem[k][i] = dv_rem_r[k][i];
        st_quo[k][i] = dv_quo_r[k][i];
        if (dv_rem_r[k][i] >= dvs) begin
          st_rem[k][i] = dv_rem_r[k][i] - dvs;
          st_quo[k][i][DIV_STEPS-1-k] = 1'b1;
        end
      end
    end
  end

  // Final pixel from the last divider step.
  logic [31:0] fin_pix;

  always_comb begin
    fin_pix = {dv_na_r[DIV_STEPS], 24'd0};
    for (int i = 0; i < 3; i++) begin
      fin_pix[8*i +: 8] = dv_sat_r[DIV_STEPS][i] ? 8'hFF : dv_quo_r[DIV_STEPS][i];
    end
    if (dv_nodiv_r[DIV_STEPS]) begin
      fin_pix = dv_pix_r[DIV_STEPS];
    end
  end

  // Valid bits of every stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) dv_valid_r[k] <= 1'b0;
    end else if (en) begin
      a_valid_r     <= head_valid;
      b_valid_r     <= a_valid_r;
      c_valid_r     <= b_valid_r;
      dv_valid_r[0] <= c_valid_r;
      for (int k = 0; k < DIV_STEPS; k++) dv_valid_r[k+1] <= dv_valid_r[k];
      o_valid_r     <= dv_valid_r[DIV_STEPS];
    end
  end

  // Payload registers of every stage.
  always_ff @(posedge clk) begin
    if (en) begin
      a_item_r <= head_item;

      b_op_r  <= a_item_r.op;
      b_p_r   <= a_item_r.p;
      b_q_r   <= a_item_r.q;
      b_pix_r <= a_item_r.pix;
      b_fa_r  <= ab_fa;
      b_g2a_r <= ab_g2a;
      b_g2b_r <= ab_g2b;
      for (int i = 0; i < 3; i++) begin
        b_x_r[i] <= ab_x[i];
        b_y_r[i] <= ab_y[i];
      end

      c_op_r  <= b_op_r;
      c_p_r   <= b_p_r;
      c_pix_r <= b_pix_r;
      c_na_r  <= bc_na;
      for (int i = 0; i < 3; i++) begin
        c_pp_r[i] <= bc_pp[i];
        c_qq_r[i] <= bc_qq[i];
      end

      dv_na_r[0]    <= c_na_r;
      dv_nodiv_r[0] <= cd_nodiv;
      dv_pix_r[0]   <= cd_pix;
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= cd_num[i];
        dv_quo_r[0][i] <= '0;
        dv_sat_r[0][i] <= cd_sat[i];
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
        dv_na_r[k+1]    <= dv_na_r[k];
        dv_nodiv_r[k+1] <= dv_nodiv_r[k];
        dv_pix_r[k+1]   <= dv_pix_r[k];
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[k+1][i] <= st_rem[k][i];
          dv_quo_r[k+1][i] <= st_quo[k][i];
          dv_sat_r[k+1][i] <= dv_sat_r[k][i];
        end
      end

      o_pixel_r <= fin_pix;
    end
  end

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && out_stall) |=> (c_valid_r == $past(c_valid_r)))
    else $error("pipeline advanced while output was held");

  a_pop_only_when_moving: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> en) else $error("queue popped while pipeline stalled");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_valid_r[DIV_STEPS] && !dv_nodiv_r[DIV_STEPS] && !dv_sat_r[DIV_STEPS][0])
    |-> (dv_rem_r[DIV_STEPS][0] < {9'd0, dv_na_r[DIV_STEPS]}))
    else $error("divider remainder not below divisor");

endmodule

@@ rtl/porter_duff_pixel_compositor.sv @@
// Porter-Duff pixel compositor top level: configuration register, front
// end, word queue and arithmetic back end. Depends on pdc_pkg, pdc_front,
// pdc_queue and pdc_back.
//
// The compositor takes one source/destination pixel pair per clock while
// in_stall is low and returns one composited pixel per pair, in order. Each
// word passes a four-entry queue and a fixed pipeline of two multiply stages,
// a combine stage, an eight-step divider for the colour bytes and an output
// register; the divider works out one quotient bit per stage. The sustained
// rate is one pixel per cycle while the output is not stalled. The blend
// rule register sits at address 0 and resets to source-over; it should be
// written only while no pixel is in flight.
module porter_duff_pixel_compositor
  import pdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_src_pixel,
  input  logic [31:0] in_dst_pixel,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_new_pixel
);

  logic [3:0] blend_rule_r;
  logic       reg_hit;
  pdc_item_t  front_item;
  pdc_item_t  head_item;
  logic       q_full, q_pop, head_valid;

  // Register access.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_BLEND_RULE);
  assign prdata  = reg_hit ? {28'd0, blend_rule_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_rule_r <= RULE_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      blend_rule_r <= pwdata[3:0];
    end
  end

  assign in_stall = q_full;

  pdc_front u_front (
    .rule      (blend_rule_r),
    .src_pixel (in_src_pixel),
    .dst_pixel (in_dst_pixel),
    .item      (front_item)
  );

  pdc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid && !q_full),
    .push_item  (front_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  pdc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_new_pixel (out_new_pixel)
  );

endmodule

@@ dv/tb_porter_duff_pixel_compositor.sv @@
// Self-checking bench for the Porter-Duff pixel compositor: directed and random pixel
// pairs under every blend rule, checked against an in-bench compositing predictor.
// Depends on pdc_pkg and porter_duff_pixel_compositor.
module tb_porter_duff_pixel_compositor;
  import pdc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIMEOUT_CYCLES = 400000;
  localparam int DRAIN_CYCLES   = 40;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid, in_stall;
  logic [31:0] in_src_pixel, in_dst_pixel;
  logic        out_valid, out_stall;
  logic [31:0] out_new_pixel;

  logic [3:0]  rule_shadow;
  logic [31:0] pending_pixels[$];
  int          send_idle_pct, stall_pct;
  int          hold_off_cycles;
  int          failures;
  longint      cycle_count;

  porter_duff_pixel_compositor dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Fail the run if it hangs.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > TIMEOUT_CYCLES) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Predictor helpers.
  function automatic logic [31:0] div_255(input logic [31:0] x);
    logic [31:0] t;
    t = x + 32'h80;
    return ((t >> 8) + t) >> 8;
  endfunction

  function automatic logic [31:0] clip8(input logic [31:0] x);
    return (x > 32'd255) ? 32'd255 : x;
  endfunction

  function automatic logic [31:0] byte_of(input logic [31:0] px, input int i);
    return (px >> (8 * i)) & 32'hFF;
  endfunction

  function automatic logic [31:0] set_alpha(input logic [31:0] px, input logic [31:0] a);
    return (px & 32'h00FF_FFFF) | ((a & 32'hFF) << 24);
  endfunction

  function automatic logic [31:0] blend_over_opaque(input logic [31:0] p, input logic [31:0] q);
    logic [31:0] a, ca, r;
    a = p[31:24];
    a = a + (a >> 7);
    ca = 256 - a;
    r = 32'hFF00_0000;
    for (int i = 0; i < 3; i++)
      r |= clip8((byte_of(p, i) * a + byte_of(q, i) * ca) >> 8) << (8 * i);
    return r;
  endfunction

  function automatic logic [31:0] blend_over(input logic [31:0] p, input logic [31:0] q);
    logic [31:0] pa, qa, na, a, ca, b, r, v;
    pa = p[31:24];
    qa = q[31:24];
    na = (pa + qa - div_255(qa * pa)) & 32'hFF;
    if (na == 0) return 0;
    a = pa + (pa >> 7);
    ca = 256 - a;
    b = qa + (qa >> 7);
    r = na << 24;
    for (int i = 0; i < 3; i++) begin
      v = (byte_of(p, i) * a + ((byte_of(q, i) * b * ca) >> 8)) >> 8;
      r |= clip8(v * 255 / na) << (8 * i);
    end
    return r;
  endfunction

  function automatic logic [31:0] blend_in(input logic [31:0] p, input logic [31:0] q);
    logic [31:0] na;
    na = div_255(p[31:24] * q[31:24]) & 32'hFF;
    return (na == 0) ? 32'd0 : set_alpha(p, na);
  endfunction

  function automatic logic [31:0] blend_out(input logic [31:0] p, input logic [31:0] q);
    logic [31:0] pa, cq, na, r;
    pa = p[31:24];
    cq = 255 - q[31:24];
    na = div_255(pa * cq) & 32'hFF;
    if (na == 0) return 0;
    r = na << 24;
    for (int i = 0; i < 3; i++)
      r |= clip8(div_255(byte_of(p, i) * pa * cq) / na) << (8 * i);
    return r;
  endfunction

  function automatic logic [31:0] blend_atop(input logic [31:0] p, input logic [31:0] q);
    logic [31:0] pa, qa, a, ca, b, r, v;
    pa = p[31:24];
    qa = q[31:24];
    if (qa == 0) return 0;
    a = pa + (pa >> 7);
    ca = 256 - a;
    b = qa + (qa >> 7);
    r = qa << 24;
    for (int i = 0; i < 3; i++) begin
      v = (byte_of(p, i) * a * b + byte_of(q, i) * b * ca) >> 16;
      r |= clip8(v * 255 / qa) << (8 * i);
    end
    return r;
  endfunction

  function automatic logic [31:0] blend_xor(input logic [31:0] p, input logic [31:0] q);
    logic [31:0] pa, qa, fp, fq, na, r;
    pa = p[31:24];
    qa = q[31:24];
    fp = pa * (255 - qa);
    fq = qa * (255 - pa);
    na = div_255(fp + fq) & 32'hFF;
    if (na == 0) return 0;
    r = na << 24;
    for (int i = 0; i < 3; i++)
      r |= clip8(div_255(byte_of(p, i) * fp + byte_of(q, i) * fq) / na) << (8 * i);
    return r;
  endfunction

  // Composited pixel for one source/destination pair under the current rule.
  function automatic logic [31:0] composite_pixel(input logic [3:0] rule,
                                                  input logic [31:0] s, input logic [31:0] d);
    logic [31:0] sa, da;
    sa = s[31:24];
    da = d[31:24];
    case (rule)
      RULE_CLEAR: return 0;
      RULE_SRC: return s;
      RULE_SRC_OVER: begin
        if (sa == 0) return d;
        if (sa == 255 || da == 0) return s;
        if (da == 255) return blend_over_opaque(s, d);
        return blend_over(s, d);
      end
      RULE_DST_OVER: begin
        if (sa == 0 || da == 255) return d;
        if (da == 0) return s;
        if (sa == 255) return blend_over_opaque(d, s);
        return blend_over(d, s);
      end
      RULE_SRC_IN: begin
        if (sa == 0 || da == 0) return 0;
        if (da == 255) return s;
        if (sa == 255) return set_alpha(s, da);
        return blend_in(s, d);
      end
      RULE_DST_IN: begin
        if (sa == 255) return d;
        if (sa == 0 || da == 0) return 0;
        if (da == 255) return set_alpha(d, sa);
        return blend_in(d, s);
      end
      RULE_SRC_OUT: begin
        if (sa == 0 || da == 255) return 0;
        if (da == 0) return s;
        if (sa == 255) return set_alpha(s, 255 - da);
        return blend_out(s, d);
      end
      RULE_DST_OUT: begin
        if (sa == 0) return d;
        if (sa == 255 || da == 0) return 0;
        if (da == 255) return set_alpha(d, 255 - sa);
        return blend_out(d, s);
      end
      RULE_SRC_ATOP: begin
        if (sa == 0) return d;
        if (da == 0) return 0;
        if (sa == 255) return set_alpha(s, da);
        if (da == 255) return blend_over_opaque(s, d);
        return blend_atop(s, d);
      end
      RULE_DST_ATOP: begin
        if (sa == 0) return 0;
        if (da == 0) return s;
        if (sa == 255) return blend_over_opaque(d, s);
        if (da == 255) return set_alpha(d, sa);
        return blend_atop(d, s);
      end
      RULE_XOR: begin
        if (sa == 0) return d;
        if (da == 0) return s;
        if (sa == 255) return set_alpha(s, 255 - da);
        if (da == 255) return set_alpha(d, 255 - sa);
        return blend_xor(s, d);
      end
      default: return d;
    endcase
  endfunction

  // Receiver: random stall, with an optional long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result checker: compare every accepted word with the oldest prediction.
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("new_pixel: unexpected word, actual %h", out_new_pixel);
        failures++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_new_pixel !== want) begin
          $error("new_pixel: expected %h, actual %h", want, out_new_pixel);
          failures++;
        end
      end
    end
  end

  // Register write over the configuration port, done while the block is idle.
  task automatic write_rule(input logic [3:0] rule);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_BLEND_RULE, 2'b00};
    pwdata <= {28'd0, rule};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    rule_shadow = rule;
  endtask

  // Offer one pixel pair and wait for it to be taken.
  task automatic send_pair(input logic [31:0] s, input logic [31:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_src_pixel <= s;
    in_dst_pixel <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_pixels.push_back(composite_pixel(rule_shadow, s, d));
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_alpha_pixel();
    logic [7:0] a;
    case ($urandom_range(3))
      0: a = 8'd0;
      1: a = 8'd255;
      default: a = 8'($urandom_range(255));
    endcase
    return {a, 24'($urandom)};
  endfunction

  // Alpha extremes, saturating colour and the out-of-range rule codes.
  task automatic test_directed();
    logic [31:0] alphas[5];
    alphas = '{32'h00, 32'h01, 32'h80, 32'hFE, 32'hFF};
    send_idle_pct = 0;
    stall_pct = 0;
    for (int r = 0; r < 16; r++) begin
      write_rule(4'(r));
      send_pair(32'hFFFF_FFFF, 32'h0000_0000);
      send_pair(32'h00AB_CDEF, 32'hFF12_3456);
      send_pair(32'h80FF_FFFF, 32'h01FF_FFFF);
      send_pair(32'h7F00_FF00, 32'h80FF_00FF);
      for (int i = 0; i < 5; i++)
        send_pair({alphas[i][7:0], 24'hFF_80_01}, {alphas[4 - i][7:0], 24'h01_7F_FE});
      wait_drained();
    end
  endtask

  // Random pairs under every rule and several idle mixes.
  task automatic test_random_rules();
    int idle_mix[4][2];
    idle_mix = '{'{0, 0}, '{58, 0}, '{0, 58}, '{35, 35}};
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_mix[ph][0];
      stall_pct = idle_mix[ph][1];
      for (int r = 0; r < 12; r++) begin
        write_rule(4'(r));
        for (int n = 0; n < 38; n++) send_pair(rand_alpha_pixel(), rand_alpha_pixel());
        wait_drained();
      end
    end
  endtask

  // Long receiver hold-off fills the queue and stalls the input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 20;
    write_rule(RULE_XOR);
    hold_off_cycles <= 60;
    for (int n = 0; n < 100; n++) send_pair(rand_alpha_pixel(), rand_alpha_pixel());
    go_idle();
    wait_drained();
    write_rule(RULE_DST_ATOP);
    for (int n = 0; n < 50; n++) send_pair($urandom, $urandom);
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_src_pixel = '0;
    in_dst_pixel = '0;
    out_stall = 1'b0;
    hold_off_cycles = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    failures = 0;
    rule_shadow = RULE_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // A few words at the reset rule before any write.
    for (int n = 0; n < 4; n++) send_pair(rand_alpha_pixel(), rand_alpha_pixel());
    wait_drained();
    test_directed();
    test_random_rules();
    test_backpressure();
    if (failures == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/pdc_pkg.sv
rtl/pdc_front.sv
rtl/pdc_queue.sv
rtl/pdc_back.sv
rtl/porter_duff_pixel_compositor.sv
dv/tb_porter_duff_pixel_compositor.sv
